>>> rtl/qrm_pkg.sv
// Shared types, constants and helpers for the quad rotor mixer.
// Used by quad_rotor_mixer, qrm_checker and the bench; no dependencies.
`default_nettype none

package qrm_pkg;

   localparam int ROTORS    = 4;
   localparam int RIDX_W    = 2;
   localparam int CSR_IDX_W = RIDX_W + 1;
   localparam int SCALE_W   = 48;
   localparam int CMD_W     = 16;
   localparam int OUT_W     = 15;
   localparam int MIX_W     = 34;
   localparam int FRAC_W    = 14;

   localparam logic signed [CMD_W-1:0] ONE_Q14     = 16'sd16384;
   localparam logic signed [CMD_W-1:0] NEG_ONE_Q14 = -16'sd16384;
   localparam logic [OUT_W-1:0]        FULL_OUT    = 15'd16384;
   localparam logic signed [MIX_W-1:0] ONE_Q28     = 34'sd268435456;

   // Divider geometry: yaw limit, roll/pitch rescale, output scale
   localparam int YAW_NW = 31;
   localparam int YAW_DW = 16;
   localparam int YAW_QW = 15;
   localparam int RPT_W  = 46;
   localparam int RSC_NW = RPT_W + FRAC_W;
   localparam int RSC_DW = 32;
   localparam int RSC_QW = 31;
   localparam int SCL_NW = 31 + FRAC_W;
   localparam int SCL_DW = 32;
   localparam int SCL_QW = 14;

   // Clock edges from a command transfer to its result transfer
   localparam int LATENCY = 4 + ROTORS * (1 + YAW_QW) + 1 + RSC_QW + 1 + SCL_QW + 1;

   localparam logic [ROTORS-1:0][SCALE_W-1:0] SCALE_RESET = {
      48'hC000_C000_0000,
      48'hC000_4000_0000,
      48'h4000_0000_4000,
      48'h4000_0000_C000
   };

   // Per-item context carried down the pipeline
   typedef struct packed {
      logic [CMD_W-1:0]             yaw;
      logic [OUT_W-1:0]             thrust;
      logic [ROTORS-1:0][MIX_W-1:0] rp;
      logic [ROTORS-1:0][MIX_W-1:0] mix;
      logic [MIX_W-1:0]             mn;
      logic [MIX_W-1:0]             mx;
      logic                         lim;
      logic                         flip;
   } ctx_type;

   function automatic logic signed [CMD_W-1:0] roll_gain(input logic [SCALE_W-1:0] s);
      return $signed(s[15:0]);
   endfunction

   function automatic logic signed [CMD_W-1:0] pitch_gain(input logic [SCALE_W-1:0] s);
      return $signed(s[31:16]);
   endfunction

   function automatic logic signed [CMD_W-1:0] yaw_gain(input logic [SCALE_W-1:0] s);
      return $signed(s[47:32]);
   endfunction

   // Clamp to [-1, 1] in Q2.14
   function automatic logic signed [CMD_W-1:0] clamp_sym(input logic signed [CMD_W-1:0] v);
      if (v > ONE_Q14) begin
         return ONE_Q14;
      end else if (v < NEG_ONE_Q14) begin
         return NEG_ONE_Q14;
      end
      return v;
   endfunction

   // Clamp to [0, 1]: Q2.14 in, unsigned Q1.14 out
   function automatic logic [OUT_W-1:0] clamp_thrust(input logic signed [CMD_W-1:0] v);
      if (v[CMD_W-1]) begin
         return '0;
      end else if (v > ONE_Q14) begin
         return FULL_OUT;
      end
      return v[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/qrm_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Depends on nothing; carries an opaque side vector alongside the lanes.
`default_nettype none

module qrm_div_pipe #(
   parameter int LANES  = 1,
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 16,
   parameter int QUO_W  = 16,
   parameter int SIDE_W = 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_vld,
   input  wire logic [LANES-1:0][NUM_W-1:0]  in_num,
   input  wire logic [LANES-1:0][DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0]            in_side,
   output logic                              out_vld,
   output logic [LANES-1:0][QUO_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]                 out_side
);

   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [QUO_W-1:0]              vld_ff;
   logic [LANES-1:0][NUM_W-1:0]   rem_ff  [QUO_W];
   logic [LANES-1:0][DEN_W-1:0]   den_ff  [QUO_W];
   logic [LANES-1:0][QUO_W-1:0]   quo_ff  [QUO_W];
   logic [SIDE_W-1:0]             side_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int K = QUO_W - 1 - s;

      logic                        vld_src;
      logic [LANES-1:0][NUM_W-1:0] rem_src;
      logic [LANES-1:0][DEN_W-1:0] den_src;
      logic [LANES-1:0][QUO_W-1:0] quo_src;
      logic [SIDE_W-1:0]           side_src;
      logic [LANES-1:0][NUM_W-1:0] rem_in;
      logic [LANES-1:0][QUO_W-1:0] quo_in;

      if (s == 0) begin : g_first
         assign vld_src  = in_vld;
         assign rem_src  = in_num;
         assign den_src  = in_den;
         assign quo_src  = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign quo_src  = quo_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // Try subtracting the shifted divisor, keep the bit
      always_comb begin
         logic [CMP_W-1:0] trial;
         logic [CMP_W-1:0] remx;
         logic             ge;
         for (int l = 0; l < LANES; l++) begin
            trial     = CMP_W'(den_src[l]) << K;
            remx      = CMP_W'(rem_src[l]);
            ge        = (remx >= trial);
            rem_in[l] = ge ? NUM_W'(remx - trial) : rem_src[l];
            quo_in[l] = quo_src[l] | (QUO_W'(ge) << K);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         den_ff[s]  <= den_src;
         quo_ff[s]  <= quo_in;
         side_ff[s] <= side_src;
      end
   end

   assign out_vld  = vld_ff[QUO_W-1];
   assign out_quo  = quo_ff[QUO_W-1];
   assign out_side = side_ff[QUO_W-1];

endmodule

`default_nettype wire

>>> rtl/quad_rotor_mixer.sv
// Quad rotor mixer top level: command clamp, mix, yaw limit, rescale, output scale.
// Depends on qrm_pkg and qrm_div_pipe.
//
// Takes one roll/pitch/yaw/thrust command set per clock (start while busy is low)
// and returns the four rotor throttles on a one-cycle rsp_valid strobe. Each command
// passes through a chain of pipelined dividers: four 15-stage yaw-limit dividers
// in series (the limited yaw of each rotor feeds the next), a 31-stage roll/pitch
// rescale divider and a 14-stage output scale divider, plus eleven single
// register stages (clamp, products, mix, min/max, one yaw product stage per rotor,
// rescale numerators, rescale select and the output register). busy is high only
// in reset. Results cannot be held off, so take them when rsp_valid is high. Write
// the rotor scale registers only while no command is in flight.
`default_nettype none

module quad_rotor_mixer (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire logic signed [qrm_pkg::CMD_W-1:0]       req_roll_cmd,
   input  wire logic signed [qrm_pkg::CMD_W-1:0]       req_pitch_cmd,
   input  wire logic signed [qrm_pkg::CMD_W-1:0]       req_yaw_cmd,
   input  wire logic signed [qrm_pkg::CMD_W-1:0]       req_thrust_cmd,
   output logic                                        rsp_valid,
   output logic [qrm_pkg::OUT_W-1:0]                   rsp_motor0_out,
   output logic [qrm_pkg::OUT_W-1:0]                   rsp_motor1_out,
   output logic [qrm_pkg::OUT_W-1:0]                   rsp_motor2_out,
   output logic [qrm_pkg::OUT_W-1:0]                   rsp_motor3_out,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [qrm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire logic [qrm_pkg::SCALE_W-1:0]            csr_wdata
);

   localparam int ROTORS = qrm_pkg::ROTORS;
   localparam int MIX_W  = qrm_pkg::MIX_W;
   localparam int CMD_W  = qrm_pkg::CMD_W;
   localparam int OUT_W  = qrm_pkg::OUT_W;
   localparam int FRAC_W = qrm_pkg::FRAC_W;
   localparam int SIDE_W = $bits(qrm_pkg::ctx_type);

   // ---------------------------------------------------------------
   // Rotor scale registers
   // ---------------------------------------------------------------
   logic [ROTORS-1:0][qrm_pkg::SCALE_W-1:0] rotor_scales_ff;

   assign csr_ready = 1'b1;
   assign busy      = reset;

   // Ignore writes beyond the rotor list
   always_ff @(posedge clock) begin
      if (reset) begin
         rotor_scales_ff <= qrm_pkg::SCALE_RESET;
      end else if (csr_valid && csr_ready && (csr_index < qrm_pkg::CSR_IDX_W'(ROTORS))) begin
         rotor_scales_ff[csr_index[qrm_pkg::RIDX_W-1:0]] <= csr_wdata;
      end
   end

   // ---------------------------------------------------------------
   // Stage 0: clamp commands
   // ---------------------------------------------------------------
   logic                     s0_vld_ff;
   logic signed [CMD_W-1:0]  s0_roll_ff, s0_pitch_ff, s0_yaw_ff;
   logic [OUT_W-1:0]         s0_thrust_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_roll_ff   <= qrm_pkg::clamp_sym(req_roll_cmd);
      s0_pitch_ff  <= qrm_pkg::clamp_sym(req_pitch_cmd);
      s0_yaw_ff    <= qrm_pkg::clamp_sym(req_yaw_cmd);
      s0_thrust_ff <= qrm_pkg::clamp_thrust(req_thrust_cmd);
   end

   // ---------------------------------------------------------------
   // Stage 1: roll and pitch products
   // ---------------------------------------------------------------
   logic                     s1_vld_ff;
   logic signed [CMD_W-1:0]  s1_yaw_ff;
   logic [OUT_W-1:0]         s1_thrust_ff;
   logic signed [31:0]       s1_pr_ff [ROTORS];
   logic signed [31:0]       s1_pp_ff [ROTORS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_yaw_ff    <= s0_yaw_ff;
      s1_thrust_ff <= s0_thrust_ff;
      for (int i = 0; i < ROTORS; i++) begin
         s1_pr_ff[i] <= s0_roll_ff * qrm_pkg::roll_gain(rotor_scales_ff[i]);
         s1_pp_ff[i] <= s0_pitch_ff * qrm_pkg::pitch_gain(rotor_scales_ff[i]);
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: roll+pitch mix and thrust
   // ---------------------------------------------------------------
   logic                     s2_vld_ff;
   logic signed [CMD_W-1:0]  s2_yaw_ff;
   logic [OUT_W-1:0]         s2_thrust_ff;
   logic signed [MIX_W-1:0]  s2_rp_ff  [ROTORS];
   logic signed [MIX_W-1:0]  s2_mix_ff [ROTORS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [MIX_W-1:0] rp_in;
      s2_yaw_ff    <= s1_yaw_ff;
      s2_thrust_ff <= s1_thrust_ff;
      for (int i = 0; i < ROTORS; i++) begin
         rp_in        = MIX_W'(s1_pr_ff[i]) + MIX_W'(s1_pp_ff[i]);
         s2_rp_ff[i]  <= rp_in;
         s2_mix_ff[i] <= rp_in + $signed(MIX_W'({s1_thrust_ff, FRAC_W'(0)}));
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: min and max of the first pass
   // ---------------------------------------------------------------
   logic                 s3_vld_ff;
   qrm_pkg::ctx_type     s3_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [MIX_W-1:0] mn_in;
      logic signed [MIX_W-1:0] mx_in;
      qrm_pkg::ctx_type        ctx_in;
      mn_in  = '0;
      mx_in  = '0;
      ctx_in = '0;
      for (int i = 0; i < ROTORS; i++) begin
         if (s2_mix_ff[i] < mn_in) begin
            mn_in = s2_mix_ff[i];
         end
         if (s2_mix_ff[i] > mx_in) begin
            mx_in = s2_mix_ff[i];
         end
         ctx_in.rp[i]  = s2_rp_ff[i];
         ctx_in.mix[i] = s2_mix_ff[i];
      end
      ctx_in.yaw    = s2_yaw_ff;
      ctx_in.thrust = s2_thrust_ff;
      ctx_in.mn     = mn_in;
      ctx_in.mx     = mx_in;
      ctx_in.lim    = 1'b0;
      ctx_in.flip   = 1'b0;
      s3_ctx_ff     <= ctx_in;
   end

   // ---------------------------------------------------------------
   // Yaw limit chain: one product stage and one divider per rotor
   // ---------------------------------------------------------------
   logic               yc_vld [ROTORS+1];
   qrm_pkg::ctx_type   yc_ctx [ROTORS+1];

   assign yc_vld[0] = s3_vld_ff;
   assign yc_ctx[0] = s3_ctx_ff;

   for (genvar r = 0; r < ROTORS; r++) begin : g_yaw
      logic                             ym_vld_ff;
      qrm_pkg::ctx_type                 ym_ctx_ff;
      logic signed [31:0]               ym_prod_ff;
      logic signed [CMD_W-1:0]          ysr;
      logic signed [MIX_W-1:0]          mixr;
      logic signed [MIX_W-1:0]          negp;
      logic [qrm_pkg::YAW_NW-1:0]       dnum;
      logic [qrm_pkg::YAW_DW-1:0]       dden;
      qrm_pkg::ctx_type                 din;
      logic [SIDE_W-1:0]                dout_side;
      qrm_pkg::ctx_type                 dout;
      logic                             dout_vld;
      logic [qrm_pkg::YAW_QW-1:0]       dquo;
      qrm_pkg::ctx_type                 nxt;

      always_ff @(posedge clock) begin
         if (reset) begin
            ym_vld_ff <= 1'b0;
         end else begin
            ym_vld_ff <= yc_vld[r];
         end
      end

      always_ff @(posedge clock) begin
         ym_ctx_ff  <= yc_ctx[r];
         ym_prod_ff <= $signed(yc_ctx[r].yaw) * qrm_pkg::yaw_gain(rotor_scales_ff[r]);
      end

      // Limit when a non-negative rotor would be pushed below zero
      always_comb begin
         ysr      = qrm_pkg::yaw_gain(rotor_scales_ff[r]);
         mixr     = $signed(ym_ctx_ff.mix[r]);
         negp     = -MIX_W'(ym_prod_ff);
         dnum     = mixr[qrm_pkg::YAW_NW-1:0];
         dden     = ysr[CMD_W-1] ? qrm_pkg::YAW_DW'(-ysr) : qrm_pkg::YAW_DW'(ysr);
         din      = ym_ctx_ff;
         din.lim  = !mixr[MIX_W-1] && (mixr < negp) && (ysr != '0);
         din.flip = !ysr[CMD_W-1];
      end

      qrm_div_pipe #(
         .LANES  (1),
         .NUM_W  (qrm_pkg::YAW_NW),
         .DEN_W  (qrm_pkg::YAW_DW),
         .QUO_W  (qrm_pkg::YAW_QW),
         .SIDE_W (SIDE_W)
      ) u_yaw_div (
         .clock    (clock),
         .reset    (reset),
         .in_vld   (ym_vld_ff),
         .in_num   (dnum),
         .in_den   (dden),
         .in_side  (din),
         .out_vld  (dout_vld),
         .out_quo  (dquo),
         .out_side (dout_side)
      );

      // When limited, replace yaw by -mix/ys, rounded toward zero
      always_comb begin
         dout = qrm_pkg::ctx_type'(dout_side);
         nxt  = dout;
         if (dout.lim) begin
            nxt.yaw = dout.flip ? -{1'b0, dquo} : {1'b0, dquo};
         end
      end

      assign yc_vld[r+1] = dout_vld;
      assign yc_ctx[r+1] = nxt;
   end

   // ---------------------------------------------------------------
   // Stage P: yaw products and rescale numerators
   // ---------------------------------------------------------------
   logic                          pr_vld_ff;
   qrm_pkg::ctx_type              pr_ctx_ff;
   logic signed [31:0]            pr_yprod_ff [ROTORS];
   logic [qrm_pkg::RPT_W-1:0]     pr_rpt_ff   [ROTORS];

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_vld_ff <= 1'b0;
      end else begin
         pr_vld_ff <= yc_vld[ROTORS];
      end
   end

   always_ff @(posedge clock) begin
      logic signed [MIX_W-1:0] rp_s;
      logic [MIX_W-1:0]        rp_abs;
      pr_ctx_ff <= yc_ctx[ROTORS];
      for (int i = 0; i < ROTORS; i++) begin
         rp_s   = $signed(yc_ctx[ROTORS].rp[i]);
         rp_abs = rp_s[MIX_W-1] ? MIX_W'(-rp_s) : MIX_W'(rp_s);
         pr_yprod_ff[i] <= $signed(yc_ctx[ROTORS].yaw)
                           * qrm_pkg::yaw_gain(rotor_scales_ff[i]);
         pr_rpt_ff[i]   <= qrm_pkg::RPT_W'(rp_abs[30:0])
                           * qrm_pkg::RPT_W'(yc_ctx[ROTORS].thrust);
      end
   end

   // ---------------------------------------------------------------
   // Rescale divider: |rp| * T / (T - min), with yaw mix alongside
   // ---------------------------------------------------------------
   logic [ROTORS-1:0][qrm_pkg::RSC_NW-1:0] rs_num;
   logic [ROTORS-1:0][qrm_pkg::RSC_DW-1:0] rs_den;
   qrm_pkg::ctx_type                       rs_in_ctx;
   logic                                   rs_out_vld;
   logic [ROTORS-1:0][qrm_pkg::RSC_QW-1:0] rs_quo;
   logic [SIDE_W-1:0]                      rs_out_side;
   qrm_pkg::ctx_type                       rs_out_ctx;

   always_comb begin
      logic signed [MIX_W-1:0] t28;
      logic signed [MIX_W-1:0] den_s;
      t28       = $signed(MIX_W'({pr_ctx_ff.thrust, FRAC_W'(0)}));
      den_s     = t28 - $signed(pr_ctx_ff.mn);
      rs_in_ctx = pr_ctx_ff;
      for (int i = 0; i < ROTORS; i++) begin
         rs_num[i] = {pr_rpt_ff[i], FRAC_W'(0)};
         rs_den[i] = den_s[qrm_pkg::RSC_DW-1:0];
         rs_in_ctx.mix[i] = $signed(pr_ctx_ff.mix[i]) + MIX_W'(pr_yprod_ff[i]);
      end
   end

   qrm_div_pipe #(
      .LANES  (ROTORS),
      .NUM_W  (qrm_pkg::RSC_NW),
      .DEN_W  (qrm_pkg::RSC_DW),
      .QUO_W  (qrm_pkg::RSC_QW),
      .SIDE_W (SIDE_W)
   ) u_rsc_div (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (pr_vld_ff),
      .in_num   (rs_num),
      .in_den   (rs_den),
      .in_side  (rs_in_ctx),
      .out_vld  (rs_out_vld),
      .out_quo  (rs_quo),
      .out_side (rs_out_side)
   );

   assign rs_out_ctx = qrm_pkg::ctx_type'(rs_out_side);

   // ---------------------------------------------------------------
   // Stage R: pick rescaled or yaw-mixed output
   // ---------------------------------------------------------------
   logic                 rr_vld_ff;
   qrm_pkg::ctx_type     rr_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rr_vld_ff <= 1'b0;
      end else begin
         rr_vld_ff <= rs_out_vld;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [MIX_W-1:0] t28;
      logic signed [MIX_W-1:0] q_s;
      qrm_pkg::ctx_type        ctx_in;
      t28    = $signed(MIX_W'({rs_out_ctx.thrust, FRAC_W'(0)}));
      ctx_in = rs_out_ctx;
      for (int i = 0; i < ROTORS; i++) begin
         q_s = $signed(MIX_W'(rs_quo[i]));
         if (rs_out_ctx.rp[i][MIX_W-1]) begin
            q_s = -q_s;
         end
         if (rs_out_ctx.mn[MIX_W-1]) begin
            ctx_in.mix[i] = q_s + t28;
         end
      end
      rr_ctx_ff <= ctx_in;
   end

   // ---------------------------------------------------------------
   // Output scale divider: v * 2^14 / max
   // ---------------------------------------------------------------
   logic [ROTORS-1:0][qrm_pkg::SCL_NW-1:0] sc_num;
   logic [ROTORS-1:0][qrm_pkg::SCL_DW-1:0] sc_den;
   logic                                   sc_out_vld;
   logic [ROTORS-1:0][qrm_pkg::SCL_QW-1:0] sc_quo;
   logic [SIDE_W-1:0]                      sc_out_side;
   qrm_pkg::ctx_type                       sc_out_ctx;

   always_comb begin
      for (int i = 0; i < ROTORS; i++) begin
         sc_num[i] = {rr_ctx_ff.mix[i][30:0], FRAC_W'(0)};
         sc_den[i] = rr_ctx_ff.mx[qrm_pkg::SCL_DW-1:0];
      end
   end

   qrm_div_pipe #(
      .LANES  (ROTORS),
      .NUM_W  (qrm_pkg::SCL_NW),
      .DEN_W  (qrm_pkg::SCL_DW),
      .QUO_W  (qrm_pkg::SCL_QW),
      .SIDE_W (SIDE_W)
   ) u_scl_div (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (rr_vld_ff),
      .in_num   (sc_num),
      .in_den   (sc_den),
      .in_side  (rr_ctx_ff),
      .out_vld  (sc_out_vld),
      .out_quo  (sc_quo),
      .out_side (sc_out_side)
   );

   assign sc_out_ctx = qrm_pkg::ctx_type'(sc_out_side);

   // ---------------------------------------------------------------
   // Output stage: clamp to [0, 1] as unsigned Q.14
   // ---------------------------------------------------------------
   logic                           rsp_valid_ff;
   logic [ROTORS-1:0][OUT_W-1:0]   motor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sc_out_vld;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [MIX_W-1:0] mx_s;
      logic signed [MIX_W-1:0] v_s;
      logic                    big;
      mx_s = $signed(sc_out_ctx.mx);
      big  = (mx_s > qrm_pkg::ONE_Q28);
      for (int i = 0; i < ROTORS; i++) begin
         v_s = $signed(sc_out_ctx.mix[i]);
         if (big) begin
            if (v_s <= 0) begin
               motor_ff[i] <= '0;
            end else if (v_s >= mx_s) begin
               motor_ff[i] <= qrm_pkg::FULL_OUT;
            end else begin
               motor_ff[i] <= OUT_W'(sc_quo[i]);
            end
         end else begin
            if (v_s[MIX_W-1]) begin
               motor_ff[i] <= '0;
            end else if (v_s > qrm_pkg::ONE_Q28) begin
               motor_ff[i] <= qrm_pkg::FULL_OUT;
            end else begin
               motor_ff[i] <= v_s[FRAC_W+OUT_W-1:FRAC_W];
            end
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_motor0_out = motor_ff[0];
   assign rsp_motor1_out = motor_ff[1];
   assign rsp_motor2_out = motor_ff[2];
   assign rsp_motor3_out = motor_ff[3];

endmodule

`default_nettype wire

>>> rtl/qrm_checker.sv
// Port-level checks for quad_rotor_mixer and the bind that attaches them.
// Depends on qrm_pkg for the pipeline latency and output limits.
`default_nettype none

module qrm_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic                               rsp_valid,
   input wire logic [qrm_pkg::OUT_W-1:0]          rsp_motor0_out,
   input wire logic [qrm_pkg::OUT_W-1:0]          rsp_motor1_out,
   input wire logic [qrm_pkg::OUT_W-1:0]          rsp_motor2_out,
   input wire logic [qrm_pkg::OUT_W-1:0]          rsp_motor3_out
);

   localparam int LAT = qrm_pkg::LATENCY;

   // Every accepted command produces a result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted command produced no result");

   // No result without a command that entered the pipe
   a_no_invented: assert property (@(posedge clock)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a matching command");

   // Throttles never exceed full scale
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_motor0_out <= qrm_pkg::FULL_OUT) &&
                    (rsp_motor1_out <= qrm_pkg::FULL_OUT) &&
                    (rsp_motor2_out <= qrm_pkg::FULL_OUT) &&
                    (rsp_motor3_out <= qrm_pkg::FULL_OUT))
      else $error("throttle above full scale");

   // Reset drops everything in flight
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind quad_rotor_mixer qrm_checker u_qrm_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for quad_rotor_mixer: directed and random command sets,
// rotor scale changes between phases, throttle results checked against a predictor.
// Depends on qrm_pkg and the quad_rotor_mixer RTL.
`timescale 1ns / 1ps

typedef struct {
   logic [qrm_pkg::OUT_W-1:0] motor[qrm_pkg::ROTORS];
} throttle_type;

class throttle_scoreboard;
   logic [qrm_pkg::SCALE_W-1:0] scales[qrm_pkg::ROTORS];
   throttle_type pending[$];
   int errors;

   function new();
      for (int i = 0; i < qrm_pkg::ROTORS; i++) begin
         scales[i] = qrm_pkg::SCALE_RESET[i];
      end
      errors = 0;
   endfunction

   function void write_scales(logic [qrm_pkg::CSR_IDX_W-1:0] idx,
                              logic [qrm_pkg::SCALE_W-1:0] data);
      // indexes past the last rotor are dropped by the block
      if (idx < qrm_pkg::ROTORS) begin
         scales[idx] = data;
      end
   endfunction

   static function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Mix one command set into four throttles and queue them
   function void note_command(logic signed [15:0] r, logic signed [15:0] p,
                              logic signed [15:0] y, logic signed [15:0] t);
      longint rs[4], ps[4], ys[4], rp[4], mix[4];
      longint roll, pitch, yaw, t28, mn, mx, den, v;
      throttle_type res;
      roll = clip(r, -16384, 16384);
      pitch = clip(p, -16384, 16384);
      yaw = clip(y, -16384, 16384);
      t28 = clip(t, 0, 16384) * 16384;
      mn = 0;
      mx = 0;
      for (int i = 0; i < 4; i++) begin
         rs[i] = $signed(scales[i][15:0]);
         ps[i] = $signed(scales[i][31:16]);
         ys[i] = $signed(scales[i][47:32]);
         rp[i] = roll * rs[i] + pitch * ps[i];
         mix[i] = rp[i] + t28;
         // limit yaw so it never pulls a non-negative rotor below zero
         if (mix[i] >= 0 && mix[i] < -(yaw * ys[i]) && ys[i] != 0) begin
            yaw = -mix[i] / ys[i];
         end
         if (mix[i] < mn) mn = mix[i];
         if (mix[i] > mx) mx = mix[i];
      end
      if (mn < 0) begin
         den = t28 - mn;
         for (int i = 0; i < 4; i++) begin
            mix[i] = (rp[i] * t28) / den + t28;
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            mix[i] = mix[i] + yaw * ys[i];
         end
      end
      for (int i = 0; i < 4; i++) begin
         v = mix[i];
         if (mx > 64'sd268435456) begin
            v = (v * 64'sd268435456) / mx;
         end
         v = clip(v, 0, 64'sd268435456);
         res.motor[i] = v[28:14];
      end
      pending.push_back(res);
   endfunction

   function void check_result(throttle_type got);
      throttle_type exp_set;
      if (pending.size() == 0) begin
         $error("throttle result with no command outstanding");
         errors++;
         return;
      end
      exp_set = pending.pop_front();
      for (int i = 0; i < 4; i++) begin
         if (got.motor[i] !== exp_set.motor[i]) begin
            $error("motor%0d_out expected %0d got %0d",
                   i, exp_set.motor[i], got.motor[i]);
            errors++;
         end
      end
   endfunction
endclass

module testbench;
   localparam int CMD_W   = qrm_pkg::CMD_W;
   localparam int OUT_W   = qrm_pkg::OUT_W;
   localparam int IDX_W   = qrm_pkg::CSR_IDX_W;
   localparam int SCALE_W = qrm_pkg::SCALE_W;

   localparam int CYCLE_LIMIT = 600000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [CMD_W-1:0] req_roll_cmd = '0;
   logic signed [CMD_W-1:0] req_pitch_cmd = '0;
   logic signed [CMD_W-1:0] req_yaw_cmd = '0;
   logic signed [CMD_W-1:0] req_thrust_cmd = '0;
   logic rsp_valid;
   logic [OUT_W-1:0] rsp_motor0_out, rsp_motor1_out, rsp_motor2_out, rsp_motor3_out;
   logic csr_valid = 0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [SCALE_W-1:0] csr_wdata = '0;

   throttle_scoreboard mixer_sb = new();
   int idle_pct = 0;
   longint unsigned cycles = 0;

   quad_rotor_mixer uut (.*);

   always #2 clock = ~clock;

   // Note transfers and check throttles on the rising edge
   always @(posedge clock) begin
      throttle_type got;
      if (!reset && start && !busy) begin
         mixer_sb.note_command(req_roll_cmd, req_pitch_cmd, req_yaw_cmd, req_thrust_cmd);
      end
      if (!reset && rsp_valid) begin
         got.motor[0] = rsp_motor0_out;
         got.motor[1] = rsp_motor1_out;
         got.motor[2] = rsp_motor2_out;
         got.motor[3] = rsp_motor3_out;
         mixer_sb.check_result(got);
      end
   end

   // Hard stop if the block hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("quad_rotor_mixer verification failed");
         $finish;
      end
   end

   task automatic send_command(logic signed [15:0] r, logic signed [15:0] p,
                               logic signed [15:0] y, logic signed [15:0] t);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_roll_cmd <= r;
      req_pitch_cmd <= p;
      req_yaw_cmd <= y;
      req_thrust_cmd <= t;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
      @(negedge clock);
      start <= 0;
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      mixer_sb.write_scales(idx, data);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Hold until every throttle result is back
   task automatic drain();
      @(negedge clock);
      start <= 0;
      while (mixer_sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_cmd(bit is_thrust);
      int sel;
      sel = $urandom_range(99);
      if (sel < 10) begin
         case ($urandom_range(4))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sd16384;
            3: return -16'sd16384;
            default: return 16'sd0;
         endcase
      end else if (sel < 30) begin
         return 16'($urandom());
      end else if (is_thrust) begin
         return 16'($urandom_range(16384));
      end
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   function automatic logic [SCALE_W-1:0] rand_scales(int mode);
      logic [SCALE_W-1:0] s;
      s = SCALE_W'({$urandom(), $urandom()});
      case (mode)
         0: s = {3{16'h7FFF}};
         1: s = {3{16'h8000}};
         2: s = '0;
         3: s[47:32] = '0;
         4: s = {16'($signed($urandom_range(32768)) - 16384),
                 16'($signed($urandom_range(32768)) - 16384),
                 16'($signed($urandom_range(32768)) - 16384)};
         default: ;
      endcase
      return s;
   endfunction

   initial begin
      logic signed [15:0] edge_vals[6];
      edge_vals = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd16384, -16'sd16384, 16'sd8192};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: field extremes on the reset scales
      foreach (edge_vals[i]) begin
         send_command(edge_vals[i], edge_vals[(i + 1) % 6], edge_vals[(i + 2) % 6],
                      edge_vals[(i + 3) % 6]);
      end
      send_command(16'sd16384, 16'sd16384, 16'sd16384, 16'sd0);
      send_command(16'sd16384, 16'sd0, -16'sd16384, 16'sd2000);
      send_command(-16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
      send_command(16'sd0, 16'sd0, 16'sd16384, 16'sd16384);
      send_command(16'sd0, 16'sd0, -16'sd16384, 16'sd100);
      send_command(16'sd4000, -16'sd3000, -16'sd12000, 16'sd6000);
      send_command(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
      drain();

      // Directed: scale extremes, zero yaw scale, ignored indexes
      for (int m = 0; m < 4; m++) begin
         for (int i = 0; i < 4; i++) write_csr(IDX_W'(i), rand_scales(m));
         write_csr(IDX_W'(4 + $urandom_range(3)), SCALE_W'($urandom()));
         foreach (edge_vals[i]) begin
            send_command(edge_vals[i], edge_vals[(i + 3) % 6], edge_vals[(i + 1) % 6],
                         edge_vals[(i + 5) % 6]);
         end
         drain();
      end

      // Random phases: sender gaps light, then heavy, then none
      for (int seg = 0; seg < 12; seg++) begin
         idle_pct = (seg < 4) ? 36 : (seg < 8) ? 87 : 0;
         for (int i = 0; i < 4; i++) begin
            if (seg % 4 == 0) write_csr(IDX_W'(i), qrm_pkg::SCALE_RESET[i]);
            else write_csr(IDX_W'(i),
                           rand_scales((seg % 4 == 1) ? 4 : $urandom_range(5)));
         end
         write_csr(IDX_W'(4 + $urandom_range(3)), SCALE_W'({$urandom(), $urandom()}));
         for (int n = 0; n < 133; n++) begin
            send_command(rand_cmd(0), rand_cmd(0), rand_cmd(0), rand_cmd(1));
         end
         drain();
      end

      repeat (qrm_pkg::LATENCY + 10) @(posedge clock);
      if (mixer_sb.errors == 0 && mixer_sb.pending.size() == 0) begin
         $display("quad_rotor_mixer verification clean");
      end else begin
         $display("quad_rotor_mixer verification failed");
      end
      $finish;
   end
endmodule

>>> sim.f
rtl/qrm_pkg.sv
rtl/qrm_div_pipe.sv
rtl/quad_rotor_mixer.sv
rtl/qrm_checker.sv
bench/testbench.sv
